// ===== sv/decaying_history_ring_defines.svh =====
// ----------------------------------------------------------------------------
// decaying_history_ring_defines.svh
// Assertion macros used by the history ring checker.
// ----------------------------------------------------------------------------
`ifndef DECAYING_HISTORY_RING_DEFINES_SVH
`define DECAYING_HISTORY_RING_DEFINES_SVH

// Same-cycle implication, held off while reset is active.
`define DHR_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, held off while reset is active.
`define DHR_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

// Next-cycle implication that is checked through reset as well.
`define DHR_ASSERT_RST(lbl, clk, ante, cons, msg) \
    lbl: assert property (@(posedge clk) (ante) |=> (cons)) else $error(msg);

`endif

// ===== sv/dhr_pkg.sv =====
// ----------------------------------------------------------------------------
// dhr_pkg
// Shared types and constants of the decaying history ring.
// ----------------------------------------------------------------------------
package dhr_pkg;

    localparam int RING_DEPTH_DEF    = 16;
    localparam int PAYLOAD_BYTES_DEF = 8;
    localparam int MAX_RESULTS       = 16;

    localparam int OP_W     = 2;
    localparam int ENERGY_W = 32;
    localparam int WORD_W   = 64;
    localparam int WANT_W   = 5;

    localparam logic [OP_W-1:0] OP_WRITE  = 2'd0;
    localparam logic [OP_W-1:0] OP_NEWEST = 2'd1;
    localparam logic [OP_W-1:0] OP_DECAY  = 2'd2;
    localparam logic [OP_W-1:0] OP_RECENT = 2'd3;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic write;      // store the input entry at the head
        logic load;       // set walk pointer to head minus length
        logic rd_issue;   // read the slot under the walk pointer for output
        logic dec_issue;  // read the slot under the walk pointer for decay
        logic empty;      // send one empty, final result
        logic last;       // this read is the final one of the request
    } t_dhr_cmd;

endpackage

// ===== sv/decaying_history_ring.sv =====
// Writes: busy stays low through a write and the next request may follow at once.
// Reads: the first result passes the sequencer state, the RAM read register and the result
// registers (an empty answer just its flag and result registers); results come back to back.
// Busy is held through a read walk (at most depth entries), and for decay through the walk plus
// a drain state, set by the one-read-per-cycle RAM port and the energy read-modify-write.
// Results cannot be stalled; o_strobe marks each for exactly one cycle.
// Sync reset clears head, fill count and sequencer; ring contents are kept, not cleared.
// ----------------------------------------------------------------------------
// decaying_history_ring
// Fixed-depth history ring with write, newest, decay and recent-walk requests.
// ----------------------------------------------------------------------------
module decaying_history_ring
    import dhr_pkg::*;
#(
    parameter int RING_DEPTH    = RING_DEPTH_DEF,
    parameter int PAYLOAD_BYTES = PAYLOAD_BYTES_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                start,
    output logic                busy,
    input  logic [OP_W-1:0]     i_operation,
    input  logic [ENERGY_W-1:0] i_new_energy,
    input  logic [WORD_W-1:0]   i_new_payload,
    input  logic [WORD_W-1:0]   i_now_stamp,
    input  logic [WANT_W-1:0]   i_want_count,
    output logic                o_strobe,
    output logic                o_entry_valid,
    output logic [ENERGY_W-1:0] o_entry_energy,
    output logic [WORD_W-1:0]   o_entry_payload,
    output logic [WORD_W-1:0]   o_entry_stamp,
    output logic                o_run_last
);

    localparam int CW = $clog2(RING_DEPTH + 1);

    // controller -> datapath commands, datapath -> controller fill level
    t_dhr_cmd      cmd;
    logic [CW-1:0] walk_len;
    logic [CW-1:0] held_count;

    // Sequencer: one request at a time. Writes finish in the accept cycle;
    // read and decay requests walk the ring one slot per cycle from the
    // oldest wanted entry toward the head.
    dhr_ctrl #(
        .RING_DEPTH (RING_DEPTH)
    ) u_ctrl (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_start      (start),
        .i_operation  (i_operation),
        .i_want_count (i_want_count),
        .i_held_count (held_count),
        .o_busy       (busy),
        .o_cmd        (cmd),
        .o_len        (walk_len)
    );

    // Storage plus a two-stage read pipe: RAM read register, then the
    // result registers. Decay writes back the decremented energy in the cycle
    // after each read, so the walk of reads and the write-backs overlap.
    dhr_datapath #(
        .RING_DEPTH    (RING_DEPTH),
        .PAYLOAD_BYTES (PAYLOAD_BYTES)
    ) u_datapath (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (cmd),
        .i_len           (walk_len),
        .i_new_energy    (i_new_energy),
        .i_new_payload   (i_new_payload),
        .i_now_stamp     (i_now_stamp),
        .o_held_count    (held_count),
        .o_strobe        (o_strobe),
        .o_entry_valid   (o_entry_valid),
        .o_entry_energy  (o_entry_energy),
        .o_entry_payload (o_entry_payload),
        .o_entry_stamp   (o_entry_stamp),
        .o_run_last      (o_run_last)
    );

endmodule

// ===== sv/dhr_ram.sv =====
// ----------------------------------------------------------------------------
// dhr_ram
// Simple dual-port RAM, one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module dhr_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== sv/dhr_ctrl.sv =====
// ----------------------------------------------------------------------------
// dhr_ctrl
// Request decoder and sequencer: picks the walk length and steps it out.
// ----------------------------------------------------------------------------
module dhr_ctrl
    import dhr_pkg::*;
#(
    parameter int RING_DEPTH = RING_DEPTH_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_start,
    input  logic [OP_W-1:0]                   i_operation,
    input  logic [WANT_W-1:0]                 i_want_count,
    input  logic [$clog2(RING_DEPTH+1)-1:0]   i_held_count,
    output logic                              o_busy,
    output t_dhr_cmd                          o_cmd,
    output logic [$clog2(RING_DEPTH+1)-1:0]   o_len
);

    localparam int CW   = $clog2(RING_DEPTH + 1);
    localparam int CMPW = (CW > WANT_W) ? CW : WANT_W;

    localparam logic [1:0] S_IDLE  = 2'd0;
    localparam logic [1:0] S_READ  = 2'd1;
    localparam logic [1:0] S_DECAY = 2'd2;
    localparam logic [1:0] S_DRAIN = 2'd3;

    logic [1:0]    r_state, n_state;
    logic [CW-1:0] r_left, n_left;
    logic [CMPW-1:0] cnt_x, want_x, pick;
    logic [CW-1:0]   len;
    logic            accept;

    assign accept = i_start && (r_state == S_IDLE);
    assign cnt_x  = CMPW'(i_held_count);
    assign want_x = CMPW'(i_want_count);

    // length of the walk for the request at the port
    always_comb begin
        pick = (want_x < cnt_x) ? want_x : cnt_x;
        if (pick > CMPW'(MAX_RESULTS)) begin
            pick = CMPW'(MAX_RESULTS);
        end
        case (i_operation)
            OP_NEWEST: len = (i_held_count != '0) ? CW'(1) : '0;
            OP_RECENT: len = pick[CW-1:0];
            OP_DECAY:  len = i_held_count;
            default:   len = '0;
        endcase
    end

    always_comb begin
        n_state = r_state;
        n_left  = r_left;
        o_cmd   = '0;
        o_len   = len;
        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    case (i_operation)
                        OP_WRITE: o_cmd.write = 1'b1;
                        OP_DECAY: begin
                            if (len != '0) begin
                                o_cmd.load = 1'b1;
                                n_left     = len;
                                n_state    = S_DECAY;
                            end
                        end
                        default: begin
                            if (len == '0) begin
                                o_cmd.empty = 1'b1;
                            end else begin
                                o_cmd.load = 1'b1;
                                n_left     = len;
                                n_state    = S_READ;
                            end
                        end
                    endcase
                end
            end
            S_READ: begin
                o_cmd.rd_issue = 1'b1;
                o_cmd.last     = (r_left == CW'(1));
                n_left         = r_left - 1'b1;
                if (r_left == CW'(1)) begin
                    n_state = S_IDLE;
                end
            end
            S_DECAY: begin
                o_cmd.dec_issue = 1'b1;
                n_left          = r_left - 1'b1;
                if (r_left == CW'(1)) begin
                    n_state = S_DRAIN;
                end
            end
            S_DRAIN: n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_left  <= '0;
        end else begin
            r_state <= n_state;
            r_left  <= n_left;
        end
    end

    assign o_busy = (r_state != S_IDLE);

endmodule

// ===== sv/dhr_datapath.sv =====
// ----------------------------------------------------------------------------
// dhr_datapath
// Ring storage, head and fill tracking, walk pointer, decay write-back and
// the result registers.
// ----------------------------------------------------------------------------
module dhr_datapath
    import dhr_pkg::*;
#(
    parameter int RING_DEPTH    = RING_DEPTH_DEF,
    parameter int PAYLOAD_BYTES = PAYLOAD_BYTES_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  t_dhr_cmd                        i_cmd,
    input  logic [$clog2(RING_DEPTH+1)-1:0] i_len,
    input  logic [ENERGY_W-1:0]             i_new_energy,
    input  logic [WORD_W-1:0]               i_new_payload,
    input  logic [WORD_W-1:0]               i_now_stamp,
    output logic [$clog2(RING_DEPTH+1)-1:0] o_held_count,
    output logic                            o_strobe,
    output logic                            o_entry_valid,
    output logic [ENERGY_W-1:0]             o_entry_energy,
    output logic [WORD_W-1:0]               o_entry_payload,
    output logic [WORD_W-1:0]               o_entry_stamp,
    output logic                            o_run_last
);

    localparam int AW  = $clog2(RING_DEPTH);
    localparam int CW  = $clog2(RING_DEPTH + 1);
    localparam int SW  = $clog2(2 * RING_DEPTH) + 1;
    localparam int PW  = 8 * PAYLOAD_BYTES;
    localparam int RW  = WORD_W + PW;

    logic [AW-1:0] r_head, r_addr, r_s1_addr;
    logic [CW-1:0] r_count;
    logic          r_s1_rd, r_s1_empty, r_s1_last, r_s1_dec;
    logic          r_strobe, r_valid, r_last;
    logic [ENERGY_W-1:0] r_energy;
    logic [WORD_W-1:0]   r_payload, r_stamp;

    logic [SW-1:0]       start_sum;
    logic [AW-1:0]       start_slot;
    logic                e_we, rd_en;
    logic [AW-1:0]       e_waddr;
    logic [ENERGY_W-1:0] e_wdata, e_rdata, e_dec;
    logic [RW-1:0]       rec_rdata;

    function automatic logic [AW-1:0] wrap_inc(input logic [AW-1:0] a);
        return (a == AW'(RING_DEPTH - 1)) ? '0 : a + 1'b1;
    endfunction

    // oldest slot of the walk: head minus length, modulo depth
    always_comb begin
        start_sum = SW'(r_head) + SW'(RING_DEPTH) - SW'(i_len);
        if (start_sum >= SW'(RING_DEPTH)) begin
            start_sum = start_sum - SW'(RING_DEPTH);
        end
        start_slot = start_sum[AW-1:0];
    end

    assign rd_en   = i_cmd.rd_issue || i_cmd.dec_issue;
    assign e_dec   = (e_rdata == '0) ? '0 : e_rdata - 1'b1;
    assign e_we    = i_cmd.write || r_s1_dec;
    assign e_waddr = r_s1_dec ? r_s1_addr : r_head;
    assign e_wdata = r_s1_dec ? e_dec : i_new_energy;

    dhr_ram #(
        .WIDTH (ENERGY_W),
        .DEPTH (RING_DEPTH)
    ) u_energy_ram (
        .i_clk   (i_clk),
        .i_we    (e_we),
        .i_waddr (e_waddr),
        .i_wdata (e_wdata),
        .i_re    (rd_en),
        .i_raddr (r_addr),
        .o_rdata (e_rdata)
    );

    // stamp and payload share one RAM; decay never touches it, only writes and output reads
    dhr_ram #(
        .WIDTH (RW),
        .DEPTH (RING_DEPTH)
    ) u_record_ram (
        .i_clk   (i_clk),
        .i_we    (i_cmd.write),
        .i_waddr (r_head),
        .i_wdata ({i_now_stamp, i_new_payload[PW-1:0]}),
        .i_re    (i_cmd.rd_issue),
        .i_raddr (r_addr),
        .o_rdata (rec_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head     <= '0;
            r_count    <= '0;
            r_addr     <= '0;
            r_s1_rd    <= 1'b0;
            r_s1_empty <= 1'b0;
            r_s1_dec   <= 1'b0;
            r_strobe   <= 1'b0;
        end else begin
            if (i_cmd.write) begin
                r_head <= wrap_inc(r_head);
                if (r_count != CW'(RING_DEPTH)) begin
                    r_count <= r_count + 1'b1;
                end
            end
            if (i_cmd.load) begin
                r_addr <= start_slot;
            end else if (rd_en) begin
                r_addr <= wrap_inc(r_addr);
            end
            r_s1_rd    <= i_cmd.rd_issue;
            r_s1_empty <= i_cmd.empty;
            r_s1_dec   <= i_cmd.dec_issue;
            r_strobe   <= r_s1_rd || r_s1_empty;
        end
    end

    always_ff @(posedge i_clk) begin
        r_s1_addr <= r_addr;
        r_s1_last <= i_cmd.last || i_cmd.empty;
        if (r_s1_rd || r_s1_empty) begin
            r_valid <= r_s1_rd;
            r_last  <= r_s1_last;
        end
        if (r_s1_rd) begin
            r_energy  <= e_rdata;
            r_payload <= WORD_W'(rec_rdata[PW-1:0]);
            r_stamp   <= rec_rdata[RW-1:PW];
        end else if (r_s1_empty) begin
            r_energy  <= '0;
            r_payload <= '0;
            r_stamp   <= '0;
        end
    end

    assign o_held_count    = r_count;
    assign o_strobe        = r_strobe;
    assign o_entry_valid   = r_valid;
    assign o_entry_energy  = r_energy;
    assign o_entry_payload = r_payload;
    assign o_entry_stamp   = r_stamp;
    assign o_run_last      = r_last;

endmodule

// ===== sv/dhr_chk.sv =====
// ----------------------------------------------------------------------------
// dhr_chk
// Port-level checks of the history ring result stream.
// ----------------------------------------------------------------------------
`include "decaying_history_ring_defines.svh"

module dhr_chk
    import dhr_pkg::*;
(
    input logic                i_clk,
    input logic                i_rst_n,
    input logic                busy,
    input logic                o_strobe,
    input logic                o_entry_valid,
    input logic [ENERGY_W-1:0] o_entry_energy,
    input logic [WORD_W-1:0]   o_entry_payload,
    input logic [WORD_W-1:0]   o_entry_stamp,
    input logic                o_run_last
);

    // an empty result is the only and final one of its request
    `DHR_ASSERT_IMP(a_empty_last, i_clk, i_rst_n, o_strobe && !o_entry_valid, o_run_last, "empty result not final")

    // an empty result carries all-zero fields
    `DHR_ASSERT_IMP(a_empty_zero, i_clk, i_rst_n, o_strobe && !o_entry_valid, (o_entry_energy == '0) && (o_entry_payload == '0) && (o_entry_stamp == '0), "empty result not zero")

    // results of one request come on consecutive cycles
    `DHR_ASSERT_NXT(a_run_gapless, i_clk, i_rst_n, o_strobe && !o_run_last, o_strobe, "gap inside result run")

    // reset leaves the block idle with no result
    `DHR_ASSERT_RST(a_reset_idle, i_clk, !i_rst_n, !busy && !o_strobe, "not idle after reset")

endmodule

bind decaying_history_ring dhr_chk u_dhr_chk (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .busy            (busy),
    .o_strobe        (o_strobe),
    .o_entry_valid   (o_entry_valid),
    .o_entry_energy  (o_entry_energy),
    .o_entry_payload (o_entry_payload),
    .o_entry_stamp   (o_entry_stamp),
    .o_run_last      (o_run_last)
);
